// File: rtl/graph_reachability_engine_assert.svh
// ----------------------------------------------------------------------------
// Graph reachability engine assertion macros
// Shorthand for clocked implication checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GRAPH_REACHABILITY_ENGINE_ASSERT_SVH
`define GRAPH_REACHABILITY_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GRE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("graph reachability engine: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GRE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("graph reachability engine: next-cycle check failed");

`endif

// File: rtl/gre_pkg.sv
// ----------------------------------------------------------------------------
// Graph reachability engine package
// Field widths, operation and status codes, and command/status structs.
// ----------------------------------------------------------------------------
package gre_pkg;

  // Fixed field widths.
  localparam int VertexW = 4;
  localparam int CountW  = 5;
  localparam int StatusW = 2;

  // Default capacity of the adjacency matrix.
  localparam int MaxVerticesDefault = 16;

  // Vertex count after reset.
  localparam logic [CountW-1:0] VertexCountReset = 5'd16;

  // Operation codes.
  localparam logic FuncAddEdge = 1'b0;
  localparam logic FuncQuery   = 1'b1;

  // Result codes.
  localparam logic [StatusW-1:0] StatusUnreachable = 2'd0;
  localparam logic [StatusW-1:0] StatusReachable   = 2'd1;
  localparam logic [StatusW-1:0] StatusInvalid     = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_edge;    // write one adjacency bit from the input request
    logic load_query;   // latch source and destination, seed the search
    logic advance;      // take one frontier expansion step
    logic load_result;  // move the search result into the output register
  } gre_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic search_done;  // the current query has its answer
  } gre_sts_t;

endpackage

// File: rtl/gre_ctrl.sv
// ----------------------------------------------------------------------------
// Graph reachability engine controller
// Sequences request intake, the frontier search and the output handshake.
// ----------------------------------------------------------------------------
module gre_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gre_pkg::gre_cmd_t cmd_o,
  input  gre_pkg::gre_sts_t sts_i
);

  localparam logic StIdle   = 1'b0;
  localparam logic StSearch = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic slot_free;

  // Requests are taken only while no search is running.
  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Command generation and state sequencing.
  always_comb begin
    cmd_o         = '0;
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        cmd_o.load_edge  = accept && (func_i == gre_pkg::FuncAddEdge);
        cmd_o.load_query = accept && (func_i == gre_pkg::FuncQuery);
        if (cmd_o.load_query) begin
          state_d = StSearch;
        end
      end
      StSearch: begin
        // Expand until the answer is known, then wait for a free output slot.
        cmd_o.advance     = !sts_i.search_done;
        cmd_o.load_result = sts_i.search_done && slot_free;
        if (cmd_o.load_result) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/gre_datapath.sv
// ----------------------------------------------------------------------------
// Graph reachability engine datapath
// Adjacency matrix, vertex count register, frontier expansion and result.
// ----------------------------------------------------------------------------
module gre_datapath #(
  parameter int MAX_VERTICES = gre_pkg::MaxVerticesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gre_pkg::gre_cmd_t             cmd_i,
  input  logic [gre_pkg::VertexW-1:0]   from_vertex_i,
  input  logic [gre_pkg::VertexW-1:0]   to_vertex_i,
  input  logic                          cfg_write_i,
  input  logic [gre_pkg::CountW-1:0]    cfg_vertex_count_i,
  output gre_pkg::gre_sts_t             sts_o,
  output logic [gre_pkg::StatusW-1:0]   path_status_o
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int SW = $clog2(MAX_VERTICES + 1);
  localparam int NW = 7;  // holds any vertex number, count or capacity
  localparam logic [NW-1:0] MaxV = NW'(MAX_VERTICES);
  localparam logic [SW-1:0] StepLimit = SW'(MAX_VERTICES);

  logic [MAX_VERTICES-1:0]       adj_q [MAX_VERTICES];
  logic [gre_pkg::CountW-1:0]    vertex_count_q;
  logic [gre_pkg::VertexW-1:0]   src_q, dst_q;
  logic [MAX_VERTICES-1:0]       visited_q, visited_d;
  logic [MAX_VERTICES-1:0]       frontier_q, frontier_d;
  logic [SW-1:0]                 step_q;
  logic [gre_pkg::StatusW-1:0]   status_q, result;

  logic [NW-1:0]           n_eff;
  logic [MAX_VERTICES-1:0] valid_mask;
  logic [MAX_VERTICES-1:0] reach;
  logic [NW-1:0]           from_ext, to_ext, dst_ext;
  logic [VW-1:0]           from_idx, to_idx, dst_idx;
  logic                    in_ok, query_bad, done;

  // Effective vertex count, capped at capacity, and its vertex mask.
  always_comb begin
    n_eff = (NW'(vertex_count_q) > MaxV) ? MaxV : NW'(vertex_count_q);
    for (int v = 0; v < MAX_VERTICES; v++) begin
      valid_mask[v] = (NW'(v) < n_eff);
    end
  end

  // Index extraction; indices are used only once the range check passed.
  assign from_ext = NW'(from_vertex_i);
  assign to_ext   = NW'(to_vertex_i);
  assign dst_ext  = NW'(dst_q);
  assign from_idx = from_ext[VW-1:0];
  assign to_idx   = to_ext[VW-1:0];
  assign dst_idx  = dst_ext[VW-1:0];
  assign in_ok    = (from_ext < n_eff) && (to_ext < n_eff);

  // One expansion: union of the rows of all frontier vertices.
  always_comb begin
    reach = '0;
    for (int v = 0; v < MAX_VERTICES; v++) begin
      if (frontier_q[v]) begin
        reach = reach | adj_q[v];
      end
    end
    reach = reach & valid_mask;
  end

  assign frontier_d = reach & ~visited_q;
  assign visited_d  = visited_q | frontier_d;

  // Decide the answer of the current search step, in priority order.
  always_comb begin
    query_bad = !((NW'(src_q) < n_eff) && (dst_ext < n_eff));
    done      = 1'b1;
    result    = gre_pkg::StatusUnreachable;
    priority if (query_bad) begin
      result = gre_pkg::StatusInvalid;
    end else if (src_q == dst_q) begin
      result = gre_pkg::StatusReachable;
    end else if ((frontier_q == '0) || (step_q == StepLimit)) begin
      result = gre_pkg::StatusUnreachable;
    end else if (reach[dst_idx]) begin
      result = gre_pkg::StatusReachable;
    end else begin
      done = 1'b0;
    end
  end

  assign sts_o.search_done = done;
  assign path_status_o     = status_q;

  // Adjacency matrix, vertex count and search sets.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
        adj_q[r] <= '0;
      end
      vertex_count_q <= gre_pkg::VertexCountReset;
      visited_q      <= '0;
      frontier_q     <= '0;
    end else begin
      if (cfg_write_i) begin
        vertex_count_q <= cfg_vertex_count_i;
      end
      if (cmd_i.load_edge && in_ok) begin
        adj_q[from_idx][to_idx] <= 1'b1;
      end
      // Seed the search; invalid and trivial queries leave the sets alone.
      if (cmd_i.load_query && in_ok && (from_vertex_i != to_vertex_i)) begin
        visited_q  <= MAX_VERTICES'(1) << from_idx;
        frontier_q <= MAX_VERTICES'(1) << from_idx;
      end else if (cmd_i.advance) begin
        visited_q  <= visited_d;
        frontier_q <= frontier_d;
      end
    end
  end

  // Query operands, step counter and output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_query) begin
      src_q  <= from_vertex_i;
      dst_q  <= to_vertex_i;
      step_q <= '0;
    end else if (cmd_i.advance) begin
      step_q <= step_q + SW'(1);
    end
    if (cmd_i.load_result) begin
      status_q <= result;
    end
  end

endmodule

// File: rtl/graph_reachability_engine.sv
// ----------------------------------------------------------------------------
// Graph reachability engine
// Directed graph store with breadth-first reachability queries.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_ready_o with func_i, from_vertex_i and
//   to_vertex_i. An add-edge request sets one adjacency bit, if both
//   vertices are in range, and gives no result. A query request gives one
//   path_status_o on the out_valid_o/out_ready_i channel.
//   The vertex count is written on cfg_valid_i/cfg_ready_o; the port is
//   always ready and must only be written while the engine is idle.
//   A query runs one frontier expansion per cycle over the adjacency matrix
//   until the answer is known; an invalid or self query needs no expansion.
//   No request is taken while a search runs.
//   The output register holds a finished result until it is taken; requests
//   are accepted meanwhile, but a new search that ends while the output is
//   still full waits for the slot.
//   Reset clears all edges and sets the vertex count to 16.
// ----------------------------------------------------------------------------
module graph_reachability_engine #(
  parameter int MAX_VERTICES = gre_pkg::MaxVerticesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [gre_pkg::VertexW-1:0]   from_vertex_i,
  input  logic [gre_pkg::VertexW-1:0]   to_vertex_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gre_pkg::StatusW-1:0]   path_status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gre_pkg::CountW-1:0]    cfg_vertex_count_i
);

  `include "graph_reachability_engine_assert.svh"

  gre_pkg::gre_cmd_t cmd;
  gre_pkg::gre_sts_t sts;

  // The count register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // Controller.
  gre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath.
  gre_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .from_vertex_i      (from_vertex_i),
    .to_vertex_i        (to_vertex_i),
    .cfg_write_i        (cfg_valid_i && cfg_ready_o),
    .cfg_vertex_count_i (cfg_vertex_count_i),
    .sts_o              (sts),
    .path_status_o      (path_status_o)
  );

  // A query starts a search, which blocks further requests.
  `GRE_ASSERT_NEXT(a_query_starts_search, cmd.load_query, !in_ready_o)
  // An edge insert leaves the engine ready again in the following cycle.
  `GRE_ASSERT_NEXT(a_edge_one_cycle, cmd.load_edge, in_ready_o)
  // A result is only handed over once the search has its answer.
  `GRE_ASSERT_SAME(a_result_when_done, cmd.load_result, sts.search_done)
  // A handed-over result is presented on the output next cycle.
  `GRE_ASSERT_NEXT(a_result_presented, cmd.load_result, out_valid_o)

endmodule

// File: tb/graph_reachability_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Graph reachability engine testbench
// Drives edge and query requests under random idling and checks each path
// status against a breadth-first search over a local copy of the graph.
// ----------------------------------------------------------------------------
module graph_reachability_engine_tb;

  localparam int MaxV         = gre_pkg::MaxVerticesDefault;
  localparam int SettleCycles = MaxV + 8;
  localparam int StallLimit   = 4000;
  localparam int BlockItems   = 40;
  localparam int PendDepth    = 16;

  // Block ports.
  logic                        clk_i              = 1'b0;
  logic                        rst_ni             = 1'b0;
  logic                        in_valid_i         = 1'b0;
  logic                        in_ready_o;
  logic                        func_i             = gre_pkg::FuncAddEdge;
  logic [gre_pkg::VertexW-1:0] from_vertex_i      = '0;
  logic [gre_pkg::VertexW-1:0] to_vertex_i        = '0;
  logic                        out_valid_o;
  logic                        out_ready_i        = 1'b0;
  logic [gre_pkg::StatusW-1:0] path_status_o;
  logic                        cfg_valid_i        = 1'b0;
  logic                        cfg_ready_o;
  logic [gre_pkg::CountW-1:0]  cfg_vertex_count_i = gre_pkg::VertexCountReset;

  // Local copy of the graph, the search sets and the vertex count.
  logic [MaxV-1:0]            edge_rows [MaxV];
  logic [MaxV-1:0]            visited_bits;
  logic [MaxV-1:0]            frontier_bits;
  logic [gre_pkg::CountW-1:0] vertex_count_q = gre_pkg::VertexCountReset;

  // Path statuses still owed by the block, oldest first, in a ring.
  logic [gre_pkg::StatusW-1:0] pending_status [PendDepth];
  int pend_wr = 0;
  int pend_rd = 0;

  // Idling percentages for the request and result sides.
  int send_idle_pct = 16;
  int recv_idle_pct = 87;

  // Run statistics.
  int error_count    = 0;
  int edges_stored   = 0;
  int edges_ignored  = 0;
  int reach_count    = 0;
  int unreach_count  = 0;
  int invalid_count  = 0;
  int cfg_writes     = 0;

  graph_reachability_engine #(
    .MAX_VERTICES(MaxV)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .func_i             (func_i),
    .from_vertex_i      (from_vertex_i),
    .to_vertex_i        (to_vertex_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .path_status_o      (path_status_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_vertex_count_i (cfg_vertex_count_i)
  );

  // Clock generation.
  always #5 clk_i = ~clk_i;

  initial begin
    for (int r = 0; r < MaxV; r++) begin
      edge_rows[r] = '0;
    end
    visited_bits  = '0;
    frontier_bits = '0;
  end

  // Count values above capacity behave as full capacity.
  function automatic int effective_count();
    return (vertex_count_q > MaxV) ? MaxV : int'(vertex_count_q);
  endfunction

  // Breadth-first search from src toward dst over vertices below n.
  function automatic logic [gre_pkg::StatusW-1:0] search_path(
    input logic [gre_pkg::VertexW-1:0] src,
    input logic [gre_pkg::VertexW-1:0] dst,
    input int n
  );
    logic [MaxV-1:0] live_mask;
    logic [MaxV-1:0] reach;
    if (src == dst) begin
      return gre_pkg::StatusReachable;
    end
    live_mask     = {MaxV{1'b1}} >> (MaxV - n);
    visited_bits  = '0;
    visited_bits[src] = 1'b1;
    frontier_bits = visited_bits;
    for (int step = 0; step < MaxV && frontier_bits != '0; step++) begin
      reach = '0;
      for (int v = 0; v < n; v++) begin
        if (frontier_bits[v]) begin
          reach |= edge_rows[v];
        end
      end
      reach &= live_mask;
      if (reach[dst]) begin
        return gre_pkg::StatusReachable;
      end
      frontier_bits = reach & ~visited_bits;
      visited_bits |= frontier_bits;
    end
    return gre_pkg::StatusUnreachable;
  endfunction

  // Apply one accepted request to the local graph and queue its status.
  function automatic void predict_request(input logic f,
                                          input logic [gre_pkg::VertexW-1:0] src,
                                          input logic [gre_pkg::VertexW-1:0] dst);
    int                          n;
    logic                        in_range;
    logic [gre_pkg::StatusW-1:0] status;
    n        = effective_count();
    in_range = (src < n) && (dst < n);
    if (f == gre_pkg::FuncAddEdge) begin
      if (in_range) begin
        edge_rows[src][dst] = 1'b1;
        edges_stored++;
      end else begin
        edges_ignored++;
      end
    end else begin
      status = in_range ? search_path(src, dst, n) : gre_pkg::StatusInvalid;
      pending_status[pend_wr % PendDepth] = status;
      pend_wr++;
      case (status)
        gre_pkg::StatusReachable:   reach_count++;
        gre_pkg::StatusUnreachable: unreach_count++;
        default:                    invalid_count++;
      endcase
    end
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    error_count++;
  endtask

  // Send one request, idling at random before it, and wait for acceptance.
  task automatic send_request(input logic f,
                              input logic [gre_pkg::VertexW-1:0] src,
                              input logic [gre_pkg::VertexW-1:0] dst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    from_vertex_i <= src;
    to_vertex_i   <= dst;
    do @(posedge clk_i); while (!in_ready_o);
    predict_request(f, src, dst);
  endtask

  // Write the vertex count once the engine has drained and gone idle.
  task automatic write_vertex_count(input logic [gre_pkg::CountW-1:0] value);
    in_valid_i <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i        <= 1'b1;
    cfg_vertex_count_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i    <= 1'b0;
    vertex_count_q = value;
    cfg_writes++;
  endtask

  // Result side stalls at random.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each taken result with the oldest queued status.
  always @(posedge clk_i) begin : check_results
    logic [gre_pkg::StatusW-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pend_wr == pend_rd) begin
        report_mismatch($sformatf("unexpected result, status %0d", path_status_o));
      end else begin
        want = pending_status[pend_rd % PendDepth];
        pend_rd++;
        if (path_status_o !== want) begin
          report_mismatch($sformatf("path_status got %0d, want %0d",
                                    path_status_o, want));
        end
      end
    end
  end

  // Give up when no request of any kind moves for too long.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("%0t: no request moved for %0d cycles", $time, StallLimit);
    $display("graph_reachability_engine_tb: FAIL");
    $finish;
  end

  // Empty graph, self queries, chains, duplicate edges and self loops.
  task automatic test_basic_paths();
    send_request(gre_pkg::FuncQuery, 4'd0, 4'd0);
    send_request(gre_pkg::FuncQuery, 4'd0, 4'd15);
    send_request(gre_pkg::FuncAddEdge, 4'd0, 4'd1);
    send_request(gre_pkg::FuncAddEdge, 4'd1, 4'd2);
    send_request(gre_pkg::FuncAddEdge, 4'd2, 4'd15);
    send_request(gre_pkg::FuncAddEdge, 4'd0, 4'd1);
    send_request(gre_pkg::FuncQuery, 4'd0, 4'd15);
    send_request(gre_pkg::FuncQuery, 4'd15, 4'd0);
    send_request(gre_pkg::FuncAddEdge, 4'd3, 4'd3);
    send_request(gre_pkg::FuncQuery, 4'd3, 4'd4);
    send_request(gre_pkg::FuncAddEdge, 4'd4, 4'd10);
    send_request(gre_pkg::FuncAddEdge, 4'd10, 4'd5);
    send_request(gre_pkg::FuncQuery, 4'd4, 4'd5);
  endtask

  // Count of zero, count above capacity and a single vertex.
  task automatic test_count_extremes();
    write_vertex_count(5'd0);
    send_request(gre_pkg::FuncQuery, 4'd0, 4'd0);
    send_request(gre_pkg::FuncAddEdge, 4'd4, 4'd5);
    write_vertex_count(5'd31);
    send_request(gre_pkg::FuncQuery, 4'd15, 4'd15);
    send_request(gre_pkg::FuncQuery, 4'd0, 4'd15);
    write_vertex_count(5'd1);
    send_request(gre_pkg::FuncQuery, 4'd0, 4'd0);
    send_request(gre_pkg::FuncQuery, 4'd0, 4'd1);
    send_request(gre_pkg::FuncQuery, 4'd1, 4'd0);
  endtask

  // A smaller count hides stored edges through high vertices.
  task automatic test_shrunken_count();
    write_vertex_count(5'd6);
    send_request(gre_pkg::FuncQuery, 4'd4, 4'd5);
    send_request(gre_pkg::FuncQuery, 4'd0, 4'd2);
    send_request(gre_pkg::FuncQuery, 4'd0, 4'd15);
    send_request(gre_pkg::FuncAddEdge, 4'd5, 4'd15);
    send_request(gre_pkg::FuncAddEdge, 4'd5, 4'd0);
    write_vertex_count(5'd17);
    send_request(gre_pkg::FuncQuery, 4'd4, 4'd0);
  endtask

  // Mostly counts within capacity, now and then zero or above capacity.
  function automatic logic [gre_pkg::CountW-1:0] random_count();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      return '0;
    end
    if (pick < 15) begin
      return gre_pkg::CountW'($urandom_range(3, 1));
    end
    if (pick < 25) begin
      return gre_pkg::CountW'($urandom_range(31, 17));
    end
    return gre_pkg::CountW'($urandom_range(16, 4));
  endfunction

  // Mostly vertices in use, sometimes any vertex number.
  function automatic logic [gre_pkg::VertexW-1:0] pick_vertex(input int n);
    if (n == 0 || $urandom_range(99) < 8) begin
      return gre_pkg::VertexW'($urandom_range(MaxV - 1));
    end
    return gre_pkg::VertexW'($urandom_range(n - 1));
  endfunction

  // Random blocks of edges and queries, each block under a fresh count.
  // Edges mostly run a few vertices forward, which builds long paths while
  // leaving most backward queries unreachable.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int quota);
    int                          counted;
    int                          n;
    int                          s;
    logic                        f;
    logic [gre_pkg::VertexW-1:0] src;
    logic [gre_pkg::VertexW-1:0] dst;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    counted       = 0;
    while (counted < quota) begin
      write_vertex_count(random_count());
      n = effective_count();
      for (int k = 0; k < BlockItems && counted < quota; k++) begin
        if ($urandom_range(99) < 40) begin
          f   = gre_pkg::FuncAddEdge;
          src = pick_vertex(n);
          s   = int'(src);
          if ($urandom_range(99) < 94 && s + 1 < n) begin
            dst = gre_pkg::VertexW'($urandom_range((s + 3 < n - 1) ? s + 3 : n - 1,
                                                   s + 1));
          end else begin
            dst = pick_vertex(n);
          end
        end else begin
          f   = gre_pkg::FuncQuery;
          src = pick_vertex(n);
          dst = ($urandom_range(99) < 5) ? src : pick_vertex(n);
        end
        if (f == gre_pkg::FuncQuery || (src < n && dst < n)) begin
          counted++;
        end
        send_request(f, src, dst);
      end
    end
  endtask

  // Test sequence.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_paths();
    test_count_extremes();
    test_shrunken_count();
    test_random_traffic(16, 87, 200);
    test_random_traffic(87, 16, 200);
    test_random_traffic(0, 0, 200);
    in_valid_i <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    $display("Sent %0d edges (%0d out of range) and %0d queries:",
             edges_stored + edges_ignored, edges_ignored,
             reach_count + unreach_count + invalid_count);
    $display("  %0d reachable, %0d not, %0d invalid; vertex count written %0d times.",
             reach_count, unreach_count, invalid_count, cfg_writes);
    if (error_count == 0) begin
      $display("graph_reachability_engine_tb: PASS");
    end else begin
      $display("graph_reachability_engine_tb: FAIL");
    end
    $finish;
  end

endmodule
